// File: src/ps2bdf_pkg.sv
// ----------------------------------------------------------------------------
// ps2bdf_pkg
// Shared types and constants for the PS/2 byte demux, filter and ring FIFOs.
// ----------------------------------------------------------------------------
package ps2bdf_pkg;

    localparam int RING_DEPTH = 256;
    localparam int PTR_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CNT_W      = $clog2(RING_DEPTH + 1);
    localparam int FILL_W     = 9;

    localparam logic [1:0] REQ_RX       = 2'd0;
    localparam logic [1:0] REQ_RD_KBD   = 2'd1;
    localparam logic [1:0] REQ_RD_MOUSE = 2'd2;

    localparam logic [7:0] RESP_ACK         = 8'hFA;
    localparam logic [7:0] RESP_SELFTEST_OK = 8'hAA;
    localparam logic [7:0] RESP_RESEND      = 8'hFE;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] data_byte;
        logic       aux_source;
    } t_req;

    typedef struct packed {
        logic [7:0]        read_byte;
        logic              read_valid;
        logic [FILL_W-1:0] kbd_fill;
        logic [FILL_W-1:0] mouse_fill;
    } t_res;

    typedef struct packed {
        logic       push;
        logic       pop;
        logic [7:0] data;
    } t_ring_ctl;

    typedef struct packed {
        t_ring_ctl kbd;
        t_ring_ctl mouse;
    } t_dec;

endpackage

// File: src/ps2_byte_demux_filter_fifo.sv
// ----------------------------------------------------------------------------
// ps2_byte_demux_filter_fifo
// PS/2 byte demux: filters device responses, feeds keyboard and mouse rings.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken when i_start is high and o_busy is low. o_busy stays
//   low, so one request can be issued every clock cycle.
//   Request types: received byte (filtered, then pushed to the ring chosen
//   by aux_source), read keyboard ring, read mouse ring.
//   Every request gives one result on o_res, marked by o_done for exactly
//   one cycle, the cycle after the request edge.
//   The pop data comes from the ring memory's registered read port; the
//   fill counts are the ring counters after the request.
//   A full ring overwrites its oldest byte; a read of an empty ring returns
//   read_valid 0 and read_byte 0.
//   Synchronous reset empties both rings (pointers and counts to zero);
//   memory contents are not cleared and need no clearing pass.
//   The receiver cannot stall; results must be taken when o_done is high.
// ----------------------------------------------------------------------------
module ps2_byte_demux_filter_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  ps2bdf_pkg::t_req  i_req,
    output logic              o_busy,
    output logic              o_done,
    output ps2bdf_pkg::t_res  o_res
);
    import ps2bdf_pkg::*;

    logic             w_accept;
    t_dec             w_dec;
    logic [7:0]       w_kbd_q, w_mouse_q;
    logic             w_kbd_ok, w_mouse_ok;
    logic [CNT_W-1:0] w_kbd_cnt, w_mouse_cnt;
    logic             r_done;

    assign o_busy   = 1'b0;
    assign w_accept = i_start && !o_busy;

    ps2bdf_decode u_decode (
        .i_accept (w_accept),
        .i_req    (i_req),
        .o_dec    (w_dec)
    );

    ps2bdf_ring u_kbd (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_dec.kbd),
        .o_q       (w_kbd_q),
        .o_q_valid (w_kbd_ok),
        .o_count   (w_kbd_cnt)
    );

    ps2bdf_ring u_mouse (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_dec.mouse),
        .o_q       (w_mouse_q),
        .o_q_valid (w_mouse_ok),
        .o_count   (w_mouse_cnt)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= w_accept;
        end
    end

    assign o_done           = r_done;
    assign o_res.read_byte  = w_kbd_q | w_mouse_q;
    assign o_res.read_valid = w_kbd_ok | w_mouse_ok;
    assign o_res.kbd_fill   = FILL_W'(w_kbd_cnt);
    assign o_res.mouse_fill = FILL_W'(w_mouse_cnt);

endmodule

// File: src/ps2bdf_decode.sv
// ----------------------------------------------------------------------------
// ps2bdf_decode
// Drops device response bytes and steers each other request to one ring; the unused request code touches neither.
// ----------------------------------------------------------------------------
module ps2bdf_decode (
    input  logic              i_accept,
    input  ps2bdf_pkg::t_req  i_req,
    output ps2bdf_pkg::t_dec  o_dec
);
    import ps2bdf_pkg::*;

    logic w_resp;

    assign w_resp = (i_req.data_byte == RESP_ACK) ||
                    (i_req.data_byte == RESP_SELFTEST_OK) ||
                    (i_req.data_byte == RESP_RESEND);

    always_comb begin
        o_dec            = '0;
        o_dec.kbd.data   = i_req.data_byte;
        o_dec.mouse.data = i_req.data_byte;
        if (i_accept) begin
            unique case (i_req.req_type)
                REQ_RX: begin
                    o_dec.kbd.push   = !w_resp && !i_req.aux_source;
                    o_dec.mouse.push = !w_resp &&  i_req.aux_source;
                end
                REQ_RD_KBD: begin
                    o_dec.kbd.pop = 1'b1;
                end
                REQ_RD_MOUSE: begin
                    o_dec.mouse.pop = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// File: src/ps2bdf_ring.sv
// ----------------------------------------------------------------------------
// ps2bdf_ring
// Overwrite-oldest byte ring with synchronous memory and registered pop data.
// ----------------------------------------------------------------------------
module ps2bdf_ring (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  ps2bdf_pkg::t_ring_ctl   i_ctl,
    output logic [7:0]              o_q,
    output logic                    o_q_valid,
    output logic [ps2bdf_pkg::CNT_W-1:0] o_count
);
    import ps2bdf_pkg::*;

    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(RING_DEPTH);

    logic [7:0]       r_mem [RING_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic [7:0]       r_q;
    logic             r_q_valid;
    logic             w_pop_ok;
    logic             w_full;

    assign w_full   = (r_count == CNT_FULL);
    assign w_pop_ok = i_ctl.pop && (r_count != '0);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_ctl.push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            if (w_full) begin
                n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end else begin
                n_count = r_count + 1'b1;
            end
        end else if (w_pop_ok) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            n_count  = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr  <= '0;
            r_rd_ptr  <= '0;
            r_count   <= '0;
            r_q_valid <= 1'b0;
        end else begin
            r_wr_ptr  <= n_wr_ptr;
            r_rd_ptr  <= n_rd_ptr;
            r_count   <= n_count;
            r_q_valid <= w_pop_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_mem[r_wr_ptr] <= i_ctl.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop_ok) begin
            r_q <= r_mem[r_rd_ptr];
        end else begin
            r_q <= '0;
        end
    end

    assign o_q       = r_q;
    assign o_q_valid = r_q_valid;
    assign o_count   = r_count;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("ring count above depth");

    a_full_push_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.push && w_full) |=> (r_count == CNT_FULL))
        else $error("overwrite push changed full count");

    a_empty_pop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_pop_ok |=> (r_q == '0) && !r_q_valid)
        else $error("data shown without a pop");

    a_push_pop_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_ctl.push && i_ctl.pop))
        else $error("push and pop in one request");

endmodule

// File: verif/tb_ps2_byte_demux_filter_fifo.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ps2_byte_demux_filter_fifo
// Self-checking bench for the PS/2 byte demux with response filter and rings.
// A scoreboard keeps its own copy of both overwrite-oldest rings. It predicts
// each result from every accepted request and checks the results in order.
// Stimulus starts with a directed set: empty reads, responses dropped, the
// unused request code, and extreme bytes. Random fill, drain, interleaved and
// noise bursts follow, sent in bursts with random gaps.
// ----------------------------------------------------------------------------
module tb_ps2_byte_demux_filter_fifo;
    import ps2bdf_pkg::*;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int KBD        = 0;
    localparam int MOUSE      = 1;
    localparam int NUM_ITEMS  = 1500;
    localparam int LIMIT      = 200000;

    class ring_scoreboard;
        logic [7:0] ring_mem [2][RING_DEPTH];
        int unsigned wr_ptr [2];
        int unsigned rd_ptr [2];
        int unsigned fill [2];
        t_res expected_q [$];
        int errors;

        function new();
            for (int i = 0; i < 2; i++) begin
                wr_ptr[i] = 0;
                rd_ptr[i] = 0;
                fill[i]   = 0;
            end
            errors = 0;
        endfunction

        task report(input string msg);
            $display("ERROR @%0t: %s", $time, msg);
            errors++;
        endtask

        function int unsigned next_ptr(input int unsigned p);
            return (p + 1 >= RING_DEPTH) ? 0 : p + 1;
        endfunction

        function void pop_ring(input int id, output logic [7:0] b, output logic ok);
            ok = 1'b0;
            b  = 8'h00;
            if (fill[id] != 0) begin
                b = ring_mem[id][rd_ptr[id]];
                rd_ptr[id] = next_ptr(rd_ptr[id]);
                fill[id]--;
                ok = 1'b1;
            end
        endfunction

        function void note_request(input t_req r);
            t_res e;
            int id;
            e  = '0;
            id = r.aux_source ? MOUSE : KBD;
            case (r.req_type)
                REQ_RX: begin
                    if (r.data_byte != RESP_ACK && r.data_byte != RESP_SELFTEST_OK &&
                        r.data_byte != RESP_RESEND) begin
                        ring_mem[id][wr_ptr[id]] = r.data_byte;
                        wr_ptr[id] = next_ptr(wr_ptr[id]);
                        if (fill[id] >= RING_DEPTH)
                            rd_ptr[id] = next_ptr(rd_ptr[id]);
                        else
                            fill[id]++;
                    end
                end
                REQ_RD_KBD:   pop_ring(KBD, e.read_byte, e.read_valid);
                REQ_RD_MOUSE: pop_ring(MOUSE, e.read_byte, e.read_valid);
                default: ;
            endcase
            e.kbd_fill   = fill[KBD][FILL_W-1:0];
            e.mouse_fill = fill[MOUSE][FILL_W-1:0];
            expected_q.push_back(e);
        endfunction

        task check_result(input t_res got);
            t_res e;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected result %h", got));
            end else begin
                e = expected_q.pop_front();
                if (got.read_byte !== e.read_byte)
                    report($sformatf("read_byte %h, want %h", got.read_byte, e.read_byte));
                if (got.read_valid !== e.read_valid)
                    report($sformatf("read_valid %b, want %b", got.read_valid, e.read_valid));
                if (got.kbd_fill !== e.kbd_fill)
                    report($sformatf("kbd_fill %0d, want %0d", got.kbd_fill, e.kbd_fill));
                if (got.mouse_fill !== e.mouse_fill)
                    report($sformatf("mouse_fill %0d, want %0d",
                                     got.mouse_fill, e.mouse_fill));
            end
        endtask

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_start = 1'b0;
    t_req i_req   = '0;
    logic o_busy;
    logic o_done;
    t_res o_res;

    ring_scoreboard sb;
    int burst_left = 0;
    int items_sent = 0;
    int cycle_cnt  = 0;

    ps2_byte_demux_filter_fifo DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_req   (i_req),
        .o_busy  (o_busy),
        .o_done  (o_done),
        .o_res   (o_res)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // results first: the one at this edge belongs to the previous request
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done)
                sb.check_result(o_res);
            if (i_start && !o_busy)
                sb.note_request(i_req);
        end
    end

    task automatic send(input logic [1:0] kind, input logic [7:0] b, input logic aux);
        t_req r;
        int gap;
        r.req_type   = kind;
        r.data_byte  = b;
        r.aux_source = aux;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            repeat (gap) begin
                i_start <= 1'b0;
                @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        i_start <= 1'b1;
        i_req   <= r;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        burst_left--;
        items_sent++;
    endtask

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do b = 8'($urandom);
        while (b == RESP_ACK || b == RESP_SELFTEST_OK || b == RESP_RESEND);
        return b;
    endfunction

    function automatic logic [7:0] rx_byte();
        case ($urandom_range(0, 15))
            0: return RESP_ACK;
            1: return RESP_SELFTEST_OK;
            2: return RESP_RESEND;
            default: return plain_byte();
        endcase
    endfunction

    initial begin
        int mode;
        int n;
        int id;
        int wait_cycles;
        sb = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed
        send(REQ_RD_KBD, 8'hFF, 1'b1);
        send(REQ_RD_MOUSE, 8'h00, 1'b0);
        send(REQ_UNUSED, 8'hFF, 1'b1);
        send(REQ_RX, RESP_ACK, 1'b0);
        send(REQ_RX, RESP_SELFTEST_OK, 1'b1);
        send(REQ_RX, RESP_RESEND, 1'b0);
        send(REQ_RX, RESP_ACK, 1'b1);
        send(REQ_RX, 8'h00, 1'b0);
        send(REQ_RX, 8'hFF, 1'b0);
        send(REQ_RX, 8'h01, 1'b1);
        send(REQ_RX, 8'hFF, 1'b1);
        send(REQ_UNUSED, 8'h80, 1'b0);
        send(REQ_RD_KBD, 8'h00, 1'b0);
        send(REQ_RD_KBD, 8'h00, 1'b1);
        send(REQ_RD_KBD, 8'h00, 1'b0);
        send(REQ_RD_MOUSE, 8'hFF, 1'b1);
        send(REQ_RD_MOUSE, 8'h00, 1'b0);
        send(REQ_RD_MOUSE, 8'h00, 1'b1);
        send(REQ_RX, 8'hFB, 1'b0);
        send(REQ_RX, 8'hF9, 1'b1);
        send(REQ_RX, 8'hAB, 1'b0);
        send(REQ_RD_KBD, 8'h00, 1'b0);
        send(REQ_RD_MOUSE, 8'h00, 1'b0);
        send(REQ_RD_KBD, 8'h00, 1'b0);

        // random
        while (items_sent < NUM_ITEMS) begin
            mode = $urandom_range(0, 5);
            id   = $urandom_range(0, 1);
            case (mode)
                0: begin
                    // push about a ring's depth of bytes, often past full, to exercise overwrite
                    n = $urandom_range(RING_DEPTH - 10, RING_DEPTH + 40);
                    repeat (n) send(REQ_RX, rx_byte(), 1'(id));
                end
                1: begin
                    n = $urandom_range(1, RING_DEPTH + 20);
                    repeat (n) send(id ? REQ_RD_MOUSE : REQ_RD_KBD, 8'($urandom),
                                    1'($urandom));
                end
                2, 3: begin
                    n = $urandom_range(10, 60);
                    repeat (n) begin
                        case ($urandom_range(0, 3))
                            0, 1: send(REQ_RX, rx_byte(), 1'($urandom));
                            2:    send(REQ_RD_KBD, 8'($urandom), 1'($urandom));
                            default: send(REQ_RD_MOUSE, 8'($urandom), 1'($urandom));
                        endcase
                    end
                end
                default: begin
                    n = $urandom_range(5, 30);
                    repeat (n) send(2'($urandom), 8'($urandom), 1'($urandom));
                end
            endcase
        end

        i_start <= 1'b0;
        wait_cycles = 0;
        while (sb.pending() != 0 && wait_cycles < 100) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (4) @(posedge i_clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending()));

        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: sim.f
src/ps2bdf_pkg.sv
src/ps2bdf_decode.sv
src/ps2bdf_ring.sv
src/ps2_byte_demux_filter_fifo.sv
verif/tb_ps2_byte_demux_filter_fifo.sv
